// ===== hw/rtl/tmp_pkg.sv =====
// shared types and constants of the trapezoid motion profiler
// no dependencies; used by the channel interfaces and the top level
package tmp_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned SPEED_W  = 32;
  localparam int unsigned LIMIT_W  = 31;
  localparam int unsigned ACCEL_W  = 16;
  localparam int unsigned TOL_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  // register reset values
  localparam logic [ACCEL_W-1:0] ACCEL_STEP_RST     = 16'd655;
  localparam logic [LIMIT_W-1:0] GLOBAL_MAX_RST     = 31'd65536;
  localparam logic [TOL_W-1:0]   ARRIVE_TOL_RST     = 16'd655;
  localparam logic [TOL_W-1:0]   STOP_DIST_TOL_RST  = 16'd6554;

  typedef enum logic [1:0] {
    REQ_MOVE    = 2'd0,
    REQ_DECEL   = 2'd1,
    REQ_STOP    = 2'd2,
    REQ_SET_POS = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_STEP    = 2'd0,
    CFG_GLOBAL_MAX    = 2'd1,
    CFG_ARRIVE_TOL    = 2'd2,
    CFG_STOP_DIST_TOL = 2'd3
  } cfg_idx_e;

endpackage

// ===== hw/rtl/tmp_if.sv =====
// request and result channels of the trapezoid motion profiler
// depends on tmp_pkg for field widths and the request type
interface tmp_req_if;
  logic                             valid;
  logic                             ready;
  tmp_pkg::req_type_e               req_type;
  logic signed [tmp_pkg::POS_W-1:0] target_pos;
  logic [tmp_pkg::LIMIT_W-1:0]      speed_limit;

  modport source (output valid, output req_type, output target_pos,
                  output speed_limit, input ready);
  modport sink   (input valid, input req_type, input target_pos,
                  input speed_limit, output ready);
endinterface

interface tmp_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [tmp_pkg::POS_W-1:0]   pos_out;
  logic signed [tmp_pkg::SPEED_W-1:0] speed_out;
  logic                               done_res;

  modport source (output valid, output pos_out, output speed_out,
                  output done_res, input ready);
  modport sink   (input valid, input pos_out, input speed_out,
                  input done_res, output ready);
endinterface

// ===== hw/rtl/trapezoid_motion_profiler.sv =====
// trapezoid motion profiler top level: one motion request per tick
// depends on tmp_pkg and the channel interfaces in tmp_if.sv
//
//   channel | dir | payload                                | handshake
//   --------+-----+----------------------------------------+--------------
//   req_i   | in  | req_type, target_pos, speed_limit      | valid / ready
//   res_o   | out | pos_out, speed_out, done_res           | valid / ready
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i       | write enable
//
// one request per cycle sustained while results are taken; a request passes
// the request register, then the result register. the rate is set by the
// state loop: position and speed feed the squaring and distance multipliers,
// the compares and the saturating adds, and update in the same cycle as the result.
// reset loads the register defaults and zeroes position and speed; no
// clearing pass. a stalled result holds; the request stage still takes one
// more request, then ready drops until the result is taken.
module trapezoid_motion_profiler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tmp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  tmp_req_if.sink                           req_i,
  tmp_res_if.source                         res_o
);
  import tmp_pkg::*;

  // saturate a 34 bit signed sum to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      r = x[31:0];
    end else if (x[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // configuration registers
  logic [ACCEL_W-1:0] accel_q;
  logic [LIMIT_W-1:0] gmax_q;
  logic [TOL_W-1:0]   arr_tol_q;
  logic [TOL_W-1:0]   stop_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q    <= ACCEL_STEP_RST;
      gmax_q     <= GLOBAL_MAX_RST;
      arr_tol_q  <= ARRIVE_TOL_RST;
      stop_tol_q <= STOP_DIST_TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_STEP:    accel_q    <= cfg_wdata_i[ACCEL_W-1:0];
        CFG_GLOBAL_MAX:    gmax_q     <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_ARRIVE_TOL:    arr_tol_q  <= cfg_wdata_i[TOL_W-1:0];
        CFG_STOP_DIST_TOL: stop_tol_q <= cfg_wdata_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // request stage
  logic                      in_vld_q;
  req_type_e                 in_type_q;
  logic signed [POS_W-1:0]   in_target_q;
  logic [LIMIT_W-1:0]        in_limit_q;

  // result stage
  logic                      out_vld_q;
  logic signed [POS_W-1:0]   out_pos_q;
  logic signed [SPEED_W-1:0] out_speed_q;
  logic                      out_done_q;

  // carriage state
  logic signed [POS_W-1:0]   pos_q, pos_d;
  logic signed [SPEED_W-1:0] speed_q, speed_d;
  logic                      done_d;

  // request moves into the result stage when that stage is free or drains
  logic step;
  assign step        = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_type_q   <= req_i.req_type;
      in_target_q <= req_i.target_pos;
      in_limit_q  <= req_i.speed_limit;
    end
  end

  // ---------------------------------------------------------------------
  // single pass update
  // ---------------------------------------------------------------------
  logic signed [32:0] diff;
  logic [32:0]        togo;
  logic               dir_pos;
  logic [31:0]        vmag;
  logic [63:0]        vsq;
  logic [16:0]        two_a;
  logic [49:0]        two_a_togo;
  logic [32:0]        two_a_stop;
  logic               arrive, brake, below_max, v_pos, decel_stop;
  logic signed [17:0] a_s, move_acc, decel_acc, acc_sel, acc_half;
  logic signed [33:0] pos_sum, spd_sum, lim_s;
  logic signed [31:0] pos_upd, spd_clamp;

  // remaining distance, exact in 33 bits; zero counts as negative
  assign diff    = {in_target_q[31], in_target_q} - {pos_q[31], pos_q};
  assign togo    = diff[32] ? 33'(-diff) : 33'(diff);
  assign dir_pos = !diff[32] && (diff != 33'sd0);

  assign vmag  = speed_q[31] ? 32'(-speed_q) : 32'(speed_q);
  assign v_pos = !speed_q[31] && (speed_q != 32'sd0);

  // stopping distance tests as v^2 against 2a*x
  assign vsq        = {32'd0, vmag} * {32'd0, vmag};
  assign two_a      = {accel_q, 1'b0};
  assign two_a_togo = {33'd0, two_a} * {17'd0, togo};
  assign two_a_stop = {16'd0, two_a} * {17'd0, stop_tol_q};

  assign arrive     = (togo <= {17'd0, arr_tol_q}) && (vsq < {31'd0, two_a_stop});
  assign brake      = vsq >= {14'd0, two_a_togo};
  assign below_max  = vmag < {1'b0, gmax_q};
  assign decel_stop = vmag < {16'd0, accel_q};

  assign a_s = $signed({2'b00, accel_q});

  always_comb begin
    if (brake) begin
      move_acc = dir_pos ? -a_s : a_s;
    end else if (below_max) begin
      move_acc = dir_pos ? a_s : -a_s;
    end else begin
      move_acc = 18'sd0;
    end
  end

  assign decel_acc = v_pos ? -a_s : a_s;
  assign acc_sel   = (in_type_q == REQ_DECEL) ? decel_acc : move_acc;
  // arithmetic shift gives floor of acc/2
  assign acc_half  = acc_sel >>> 1;

  assign pos_sum = {{2{pos_q[31]}}, pos_q} + {{2{speed_q[31]}}, speed_q}
                 + {{16{acc_half[17]}}, acc_half};
  assign spd_sum = {{2{speed_q[31]}}, speed_q} + {{16{acc_sel[17]}}, acc_sel};
  assign pos_upd = sat32(pos_sum);

  // clamp the move speed to the request's limit
  assign lim_s = $signed({3'b000, in_limit_q});
  always_comb begin
    if (spd_sum > lim_s) begin
      spd_clamp = lim_s[31:0];
    end else if (spd_sum < -lim_s) begin
      spd_clamp = 32'(-lim_s);
    end else begin
      spd_clamp = spd_sum[31:0];
    end
  end

  always_comb begin
    pos_d   = pos_q;
    speed_d = speed_q;
    done_d  = 1'b0;
    case (in_type_q)
      REQ_MOVE: begin
        if (arrive) begin
          speed_d = 32'sd0;
          done_d  = 1'b1;
        end else begin
          pos_d   = pos_upd;
          speed_d = spd_clamp;
        end
      end
      REQ_DECEL: begin
        if (decel_stop) begin
          speed_d = 32'sd0;
          done_d  = 1'b1;
        end else begin
          pos_d   = pos_upd;
          speed_d = sat32(spd_sum);
        end
      end
      REQ_STOP: begin
        speed_d = 32'sd0;
        done_d  = 1'b1;
      end
      REQ_SET_POS: begin
        pos_d = in_target_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      speed_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (step) begin
        pos_q   <= pos_d;
        speed_q <= speed_d;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_pos_q   <= pos_d;
      out_speed_q <= speed_d;
      out_done_q  <= done_d;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.pos_out   = out_pos_q;
  assign res_o.speed_out = out_speed_q;
  assign res_o.done_res  = out_done_q;

endmodule
